### hdl/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg: shared constants and types for the byte stack machine core
// Memory geometry, opcode and status codes, ALU helper function.
// ----------------------------------------------------------------------------
package bsm_pkg;

    localparam int MemDepth = 4096;
    localparam int AddrW    = $clog2(MemDepth);
    localparam int StackTop = 4095;

    localparam logic [AddrW-1:0] STACK_TOP_A = AddrW'(StackTop);

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_HALT    = 3'd1,
        ST_OVER    = 3'd2,
        ST_UNDER   = 3'd3,
        ST_BADADDR = 3'd4,
        ST_DIVZERO = 3'd5,
        ST_BADOP   = 3'd6,
        ST_IO      = 3'd7
    } t_status;

    localparam logic [7:0] OP_NOP   = 8'd0;
    localparam logic [7:0] OP_HALT  = 8'd1;
    localparam logic [7:0] OP_PUSH  = 8'd2;
    localparam logic [7:0] OP_POP   = 8'd3;
    localparam logic [7:0] OP_DUP   = 8'd4;
    localparam logic [7:0] OP_SWAP  = 8'd5;
    localparam logic [7:0] OP_ADD   = 8'd6;
    localparam logic [7:0] OP_SUB   = 8'd7;
    localparam logic [7:0] OP_MUL   = 8'd8;
    localparam logic [7:0] OP_DIV   = 8'd9;
    localparam logic [7:0] OP_MOD   = 8'd10;
    localparam logic [7:0] OP_NEG   = 8'd11;
    localparam logic [7:0] OP_AND   = 8'd12;
    localparam logic [7:0] OP_OR    = 8'd13;
    localparam logic [7:0] OP_XOR   = 8'd14;
    localparam logic [7:0] OP_NOT   = 8'd15;
    localparam logic [7:0] OP_SHL   = 8'd16;
    localparam logic [7:0] OP_SHR   = 8'd17;
    localparam logic [7:0] OP_EQ    = 8'd18;
    localparam logic [7:0] OP_NEQ   = 8'd19;
    localparam logic [7:0] OP_GT    = 8'd20;
    localparam logic [7:0] OP_LT    = 8'd21;
    localparam logic [7:0] OP_GTE   = 8'd22;
    localparam logic [7:0] OP_LTE   = 8'd23;
    localparam logic [7:0] OP_LDA   = 8'd24;
    localparam logic [7:0] OP_STA   = 8'd25;
    localparam logic [7:0] OP_LDI   = 8'd26;
    localparam logic [7:0] OP_STI   = 8'd27;
    localparam logic [7:0] OP_JMP   = 8'd28;
    localparam logic [7:0] OP_JZ    = 8'd29;
    localparam logic [7:0] OP_JNZ   = 8'd30;
    localparam logic [7:0] OP_CALL  = 8'd31;
    localparam logic [7:0] OP_RET   = 8'd32;
    localparam logic [7:0] OP_IO    = 8'd33;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    function automatic logic [7:0] alu8(input logic [7:0] op, input logic [7:0] a,
                                        input logic [7:0] b);
        logic [7:0] r;
        r = 8'd0;
        case (op)
            OP_ADD: r = a + b;
            OP_SUB: r = a - b;
            OP_AND: r = a & b;
            OP_OR:  r = a | b;
            OP_XOR: r = a ^ b;
            OP_SHL: r = (b >= 8'd8) ? 8'd0 : (a << b[2:0]);
            OP_SHR: r = (b >= 8'd8) ? 8'd0 : (a >> b[2:0]);
            OP_EQ:  r = {7'd0, a == b};
            OP_NEQ: r = {7'd0, a != b};
            OP_GT:  r = {7'd0, a > b};
            OP_LT:  r = {7'd0, a < b};
            OP_GTE: r = {7'd0, a >= b};
            default: r = {7'd0, a <= b};
        endcase
        return r;
    endfunction

endpackage

### hdl/byte_stack_machine_core.sv
// ----------------------------------------------------------------------------
// byte_stack_machine_core: 8-bit stack machine over one byte memory
// Sequencer that reads, modifies and writes back a single-port byte RAM.
// ----------------------------------------------------------------------------
// A load request writes its byte and then reads the stack top; a step request
// makes its memory accesses in turn (fetch, operand bytes, pops, push, final
// top read), with a bit-serial divide for divide or modulo.
// One request at a time; a new request is taken once the result is taken.
// Reset: a clearing pass zeroes all 4096 memory bytes, no request is
// taken meanwhile; pc 0, sp at stack top, status ok, running.
module byte_stack_machine_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic [11:0]             i_load_address,
    input  logic [7:0]              i_load_byte,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [2:0]              o_status,
    output logic [15:0]             o_program_counter,
    output logic [11:0]             o_stack_pointer,
    output logic                    o_is_running,
    output logic [7:0]              o_top_value
);
    import bsm_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_FETCH, S_DECODE, S_OPLO, S_OPHI, S_POP,
        S_POPW, S_EXEC, S_DIV, S_DATA, S_DATAW, S_PUSH, S_TOP, S_TOPW, S_OUT
    } t_state;

    // memory port
    logic [7:0]       mem [MemDepth];
    logic             mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [7:0]       mem_wdata;
    logic [7:0]       mem_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata <= mem[mem_addr];
    end

    t_state           r_state;
    logic [AddrW-1:0] r_clr;
    logic [15:0]      r_pc;
    logic [AddrW-1:0] r_sp;
    logic [2:0]       r_status;
    logic             r_run;
    logic [2:0]       r_fault;
    logic [7:0]       r_op;
    logic [15:0]      r_opnd;
    logic             r_opnd_ok;
    logic [7:0]       r_a;
    logic [7:0]       r_b;
    logic [7:0]       r_c;
    logic [1:0]       r_npop;
    logic [1:0]       r_popi;
    logic             r_pop_zero;
    logic [7:0]       r_push [2];
    logic [1:0]       r_npush;
    logic [1:0]       r_pushi;
    logic [15:0]      r_daddr;
    logic [AddrW-1:0] r_ld_addr;
    logic [7:0]       r_ld_byte;
    logic [3:0]       r_dcnt;
    logic [7:0]       r_quo;
    logic [8:0]       r_rem;
    logic [7:0]       r_top;

    logic             take;
    logic [8:0]       div_trial;

    assign take      = i_valid && o_ready;
    assign o_ready   = (r_state == S_IDLE);
    assign div_trial = {r_rem[7:0], r_a[7]} - {1'b0, r_b};

    // single port address mux
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_sp;
        mem_wdata = 8'd0;
        case (r_state)
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = r_clr;
            end
            S_LOAD: begin
                mem_we    = 1'b1;
                mem_addr  = r_ld_addr;
                mem_wdata = r_ld_byte;
            end
            S_FETCH: mem_addr = r_pc[AddrW-1:0];
            S_OPLO:  mem_addr = r_pc[AddrW-1:0];
            S_OPHI:  mem_addr = r_pc[AddrW-1:0] + AddrW'(1);
            S_POP:   mem_addr = r_sp + AddrW'(1);
            S_DATA: begin
                mem_addr  = r_daddr[AddrW-1:0];
                mem_we    = ((r_op == OP_STA) || (r_op == OP_STI)) &&
                            (r_daddr < 16'(MemDepth));
                mem_wdata = r_c;
            end
            S_PUSH: begin
                mem_addr  = r_sp;
                mem_we    = (r_sp != '0);
                mem_wdata = r_push[r_pushi[0]];
            end
            S_TOP:   mem_addr = r_sp + AddrW'(1);
            default: mem_addr = r_sp;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pc     <= '0;
            r_sp     <= STACK_TOP_A;
            r_status <= ST_OK;
            r_run    <= 1'b1;
            o_valid  <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AddrW'(1);
                    if (r_clr == AddrW'(MemDepth - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (take) begin
                        r_ld_addr <= i_load_address;
                        r_ld_byte <= i_load_byte;
                        r_npop    <= '0;
                        r_npush   <= '0;
                        r_popi    <= '0;
                        r_pushi   <= '0;
                        if (i_action == ACT_LOAD) begin
                            r_fault <= ST_OK;
                            r_state <= S_LOAD;
                        end else if (r_run && r_status == ST_OK) begin
                            if (r_pc >= 16'(MemDepth)) begin
                                r_fault <= ST_BADADDR;
                                r_state <= S_TOP;
                            end else begin
                                r_fault <= ST_OK;
                                r_state <= S_FETCH;
                            end
                        end else begin
                            r_fault <= ST_OK;
                            r_state <= S_TOP;
                        end
                    end
                end
                S_LOAD: r_state <= S_TOP;
                S_FETCH: begin
                    r_pc    <= r_pc + 16'd1;
                    r_state <= S_DECODE;
                end
                S_DECODE: begin
                    r_op      <= mem_rdata;
                    // immediate operand bytes; beyond memory they read as zero
                    r_opnd_ok <= (mem_rdata == OP_PUSH) ? (r_pc < 16'(MemDepth)) :
                                                          (r_pc < 16'(MemDepth - 1));
                    case (mem_rdata)
                        OP_NOP: r_state <= S_TOP;
                        OP_HALT: begin
                            r_fault <= ST_HALT;
                            r_state <= S_TOP;
                        end
                        OP_PUSH: begin
                            r_state <= S_OPLO;
                        end
                        OP_IO: begin
                            r_pc    <= r_pc + 16'd1;
                            r_fault <= ST_IO;
                            r_state <= S_TOP;
                        end
                        OP_POP, OP_DUP, OP_NEG, OP_NOT: begin
                            r_npop  <= 2'd1;
                            r_state <= S_POP;
                        end
                        OP_RET: begin
                            r_npop  <= 2'd2;
                            r_state <= S_POP;
                        end
                        OP_LDA, OP_STA, OP_JMP, OP_JZ, OP_JNZ, OP_CALL: begin
                            r_state <= S_OPLO;
                        end
                        default: begin
                            if (mem_rdata inside {[OP_SWAP:OP_LTE]}) begin
                                r_npop  <= 2'd2;
                                r_state <= S_POP;
                            end else if (mem_rdata == OP_LDI) begin
                                r_npop  <= 2'd2;
                                r_state <= S_POP;
                            end else if (mem_rdata == OP_STI) begin
                                r_npop  <= 2'd3;
                                r_state <= S_POP;
                            end else begin
                                r_fault <= ST_BADOP;
                                r_state <= S_TOP;
                            end
                        end
                    endcase
                end
                S_OPLO: r_state <= S_OPHI;
                S_OPHI: begin
                    // low operand byte is on the read port now
                    r_opnd[7:0] <= r_opnd_ok ? mem_rdata : 8'd0;
                    if (r_op == OP_PUSH) begin
                        r_pc      <= r_pc + 16'd1;
                        r_push[0] <= r_opnd_ok ? mem_rdata : 8'd0;
                        r_npush   <= 2'd1;
                        r_state   <= S_PUSH;
                    end else begin
                        r_state   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // high operand byte arrives here for 16-bit operands
                    logic [15:0] adr;
                    adr = r_opnd_ok ? {mem_rdata, r_opnd[7:0]} : 16'd0;
                    if (!r_opnd_ok) begin
                        r_fault <= ST_BADADDR;
                    end
                    r_opnd <= adr;
                    case (r_op)
                        OP_JMP: begin
                            r_pc    <= adr;
                            r_state <= S_TOP;
                        end
                        OP_CALL: begin
                            logic [15:0] ret;
                            ret        = r_pc + 16'd2;
                            r_push[0] <= ret[7:0];
                            r_push[1] <= ret[15:8];
                            r_npush   <= 2'd2;
                            r_pc      <= adr;
                            r_state   <= S_PUSH;
                        end
                        OP_LDA: begin
                            r_pc    <= r_pc + 16'd2;
                            r_daddr <= adr;
                            r_state <= S_DATA;
                        end
                        default: begin
                            // store and conditional jumps pop one byte first
                            r_pc    <= r_pc + 16'd2;
                            r_daddr <= adr;
                            r_npop  <= 2'd1;
                            r_state <= S_POP;
                        end
                    endcase
                end
                S_POP: begin
                    if (r_sp >= STACK_TOP_A) begin
                        r_fault    <= ST_UNDER;
                        r_pop_zero <= 1'b1;
                        r_state    <= S_POPW;
                    end else begin
                        r_sp       <= r_sp + AddrW'(1);
                        r_pop_zero <= 1'b0;
                        r_state    <= S_POPW;
                    end
                end
                S_POPW: begin
                    logic [7:0] v;
                    v = r_pop_zero ? 8'd0 : mem_rdata;
                    // store popped bytes: r_a first pop, r_b second, r_c third
                    case (r_popi)
                        2'd0:    r_a <= v;
                        2'd1:    r_b <= v;
                        default: r_c <= v;
                    endcase
                    r_popi <= r_popi + 2'd1;
                    if (r_popi + 2'd1 < r_npop) begin
                        r_state <= S_POP;
                    end else begin
                        // jump to the after-pop step
                        r_state <= S_DIV;
                        r_dcnt  <= 4'd0;
                    end
                end
                S_DIV: begin
                    // after-pop dispatch; divide runs here bit by bit
                    if ((r_op == OP_DIV || r_op == OP_MOD) && r_dcnt != 4'd9) begin
                        if (r_dcnt == 4'd0) begin
                            // a = second pop (dividend), b = first pop (divisor)
                            r_a   <= r_b;
                            r_b   <= r_a;
                            r_rem <= '0;
                            r_dcnt <= 4'd1;
                            if (r_a == 8'd0) begin
                                r_fault <= ST_DIVZERO;
                                r_state <= S_TOP;
                            end
                        end else begin
                            if (!div_trial[8]) begin
                                r_rem <= {1'b0, div_trial[7:0]};
                            end else begin
                                r_rem <= {r_rem[7:0], r_a[7]};
                            end
                            r_quo  <= {r_quo[6:0], ~div_trial[8]};
                            r_a    <= {r_a[6:0], 1'b0};
                            r_dcnt <= r_dcnt + 4'd1;
                        end
                    end else begin
                        if (r_op inside {OP_POP, OP_RET, OP_JZ, OP_JNZ}) begin
                            r_state <= S_TOP;
                        end else if (r_op inside {OP_STA, OP_LDI, OP_STI}) begin
                            r_state <= S_DATA;
                        end else begin
                            r_state <= S_PUSH;
                        end
                        case (r_op)
                            OP_POP: r_npush <= '0;
                            OP_DUP: begin
                                r_push[0] <= r_a;
                                r_push[1] <= r_a;
                                r_npush   <= 2'd2;
                            end
                            OP_SWAP: begin
                                r_push[0] <= r_a;
                                r_push[1] <= r_b;
                                r_npush   <= 2'd2;
                            end
                            OP_NEG: begin
                                r_push[0] <= 8'd0 - r_a;
                                r_npush   <= 2'd1;
                            end
                            OP_NOT: begin
                                r_push[0] <= ~r_a;
                                r_npush   <= 2'd1;
                            end
                            OP_DIV: begin
                                r_push[0] <= r_quo;
                                r_npush   <= 2'd1;
                            end
                            OP_MOD: begin
                                r_push[0] <= r_rem[7:0];
                                r_npush   <= 2'd1;
                            end
                            OP_MUL: begin
                                r_push[0] <= 8'(r_b * r_a);
                                r_npush   <= 2'd1;
                            end
                            OP_RET: begin
                                r_pc <= {r_a, r_b};
                            end
                            OP_JZ, OP_JNZ: begin
                                if ((r_op == OP_JZ) == (r_a == 8'd0)) begin
                                    r_pc <= r_opnd;
                                end
                            end
                            OP_STA: begin
                                r_c <= r_a;
                            end
                            OP_LDI: begin
                                r_daddr <= {r_b, r_a};
                            end
                            OP_STI: begin
                                r_daddr <= {r_b, r_a};
                            end
                            default: begin
                                r_push[0] <= alu8(r_op, r_b, r_a);
                                r_npush   <= 2'd1;
                            end
                        endcase
                    end
                end
                S_DATA: begin
                    if (r_daddr >= 16'(MemDepth)) begin
                        r_fault <= ST_BADADDR;
                        r_state <= S_TOP;
                    end else if (r_op == OP_STA || r_op == OP_STI) begin
                        r_state <= S_TOP;
                    end else begin
                        r_state <= S_DATAW;
                    end
                end
                S_DATAW: begin
                    r_push[0] <= mem_rdata;
                    r_npush   <= 2'd1;
                    r_state   <= S_PUSH;
                end
                S_PUSH: begin
                    if (r_sp == '0) begin
                        r_fault <= ST_OVER;
                    end else begin
                        r_sp <= r_sp - AddrW'(1);
                    end
                    r_pushi <= r_pushi + 2'd1;
                    if (r_pushi + 2'd1 >= r_npush) begin
                        r_state <= S_TOP;
                    end
                end
                S_TOP: begin
                    if (r_fault != ST_OK) begin
                        r_status <= r_fault;
                        r_run    <= 1'b0;
                    end
                    r_state <= S_TOPW;
                end
                S_TOPW: begin
                    r_top   <= (r_sp < STACK_TOP_A) ? mem_rdata : 8'd0;
                    o_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_status          = r_status;
    assign o_program_counter = r_pc;
    assign o_stack_pointer   = r_sp;
    assign o_is_running      = r_run;
    assign o_top_value       = r_top;

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= STACK_TOP_A) else $error("stack pointer above stack top");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_run && r_state == S_IDLE) |=> !r_run) else $error("machine restarted");
    a_status_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status != ST_OK) |-> !r_run) else $error("fault while running");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("request taken while result pending");

endmodule
